FILE: sv/brf_pkg.sv
// Package with the types and constants shared by the byte ring buffer modules.
package brf_pkg;

  localparam int CfgW   = 11;
  localparam int DataW  = 8;
  localparam int CountW = 16;
  localparam int OutW   = 10;

  typedef enum logic [3:0] {
    ACT_WRITE    = 4'd0,
    ACT_READ     = 4'd1,
    ACT_PEEK     = 4'd2,
    ACT_SKIP     = 4'd3,
    ACT_FLUSH    = 4'd4,
    ACT_FETCH    = 4'd5,
    ACT_COMPLETE = 4'd6,
    ACT_SET_HEAD = 4'd7,
    ACT_SET_TAIL = 4'd8
  } brf_action_e;

  typedef logic [OutW-1:0] brf_cnt_t;

  typedef struct packed {
    logic [3:0]        action;
    logic [DataW-1:0]  data_in;
    logic [CountW-1:0] count;
    logic              want_next;
  } brf_item_t;

  typedef struct packed {
    logic             ok;
    logic [DataW-1:0] data_out;
    brf_cnt_t         chunk_start;
    brf_cnt_t         chunk_length;
    brf_cnt_t         readable_count;
    brf_cnt_t         writable_count;
  } brf_result_t;

endpackage

FILE: sv/brf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/brf_mod.sv
// Bit-serial remainder unit that reduces a position value modulo the ring size.
module brf_mod #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [brf_pkg::CountW-1:0]       dividend_i,
  input  logic [$clog2(MAX_SLOTS+1)-1:0]   divisor_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic [$clog2(MAX_SLOTS)-1:0]     rem_o
);
  import brf_pkg::*;

  localparam int PW = $clog2(MAX_SLOTS);
  localparam int SW = $clog2(MAX_SLOTS + 1);
  localparam int NW = $clog2(CountW + 1);

  logic [CountW-1:0] dvd_q, dvd_d;
  logic [SW-1:0]     rem_q, rem_d;
  logic [NW-1:0]     cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [SW:0]       trial;

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    trial  = {rem_q, dvd_q[CountW-1]};
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      cnt_d = NW'(CountW);
    end else if (cnt_q != '0) begin
      dvd_d = {dvd_q[CountW-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = SW'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[SW-1:0];
      end
      cnt_d  = cnt_q - NW'(1);
      done_d = (cnt_q == NW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign rem_o  = PW'(rem_q);

endmodule

FILE: sv/byte_ring_fifo_dma_chunks.sv
// Top level of the byte ring buffer with DMA chunk fetch.
//
// An item is one operation on the buffer. It is taken at a rising edge where
// start is high and busy is low. Its result appears on result_o, marked by
// result_valid_o, for exactly one cycle, starting the cycle after the item is
// taken (but for set head and set tail); the receiver always takes it. Every
// result carries the readable and writable counts after the operation.
// Write, read, peek, skip, flush, fetch and completion leave busy low, and a new
// item may be given in every cycle while busy is low. Read and peek data come
// from the byte memory's registered read port in the result cycle.
// Set head and set tail reduce the position modulo the ring size in a
// bit-serial remainder unit of 16 steps followed by an update of the position,
// so such an item keeps busy high until the position is updated, and its result
// is on the ports in the cycle that follows, when busy is low again.
// Writing the ring size register clears both positions and the transfer state;
// the user must do it only while the block is idle; the block does not enforce it.
// Reset clears positions and transfer state and sets the ring size to its
// default. The byte memory is not cleared and may be read where never written.
module byte_ring_fifo_dma_chunks #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  brf_pkg::brf_item_t        item_i,
  output logic                      result_valid_o,
  output brf_pkg::brf_result_t      result_o,
  input  logic                      cfg_we_i,
  input  logic [brf_pkg::CfgW-1:0]  cfg_wdata_i
);
  import brf_pkg::*;

  localparam int PW        = $clog2(MAX_SLOTS);
  localparam int SW        = $clog2(MAX_SLOTS + 1);
  localparam int SumW      = PW + 1;
  localparam int ResetSize = (1024 > MAX_SLOTS) ? MAX_SLOTS : 1024;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a,
                                             input logic [PW-1:0] b,
                                             input logic [SW-1:0] s);
    logic [SumW-1:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= SumW'(s)) begin
      return PW'(sum - SumW'(s));
    end
    return PW'(sum);
  endfunction

  function automatic logic [PW-1:0] held_f(input logic [PW-1:0] w,
                                           input logic [PW-1:0] r,
                                           input logic [SW-1:0] s);
    if (w >= r) begin
      return w - r;
    end
    return PW'(s - SW'(r) + SW'(w));
  endfunction

  logic [SW-1:0] size_q, size_d;
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d, tlen_q, tlen_d;
  logic          tbusy_q, tbusy_d;
  logic          valid_q, valid_d;
  logic          ok_q, ok_d, rdsel_q, rdsel_d;
  logic [PW-1:0] cstart_q, cstart_d, clen_q, clen_d;
  logic          tail_q, tail_d;

  logic          accept;
  logic [PW-1:0] held_q, held_c, rp_c, skip_n, raddr;
  logic          ram_we;
  logic [DataW-1:0] rdata;
  logic          mod_start, mod_busy, mod_done;
  logic [PW-1:0] mod_rem;

  assign busy   = mod_busy | mod_done;
  assign accept = start & ~busy;
  assign held_q = held_f(wp_q, rp_q, size_q);

  always_comb begin
    size_d    = size_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    tlen_d    = tlen_q;
    tbusy_d   = tbusy_q;
    tail_d    = tail_q;
    valid_d   = 1'b0;
    ok_d      = 1'b0;
    rdsel_d   = 1'b0;
    cstart_d  = '0;
    clen_d    = '0;
    ram_we    = 1'b0;
    mod_start = 1'b0;
    rp_c      = rp_q;
    held_c    = held_q;
    skip_n    = (32'(item_i.count) < 32'(held_q)) ? PW'(item_i.count) : held_q;
    raddr     = wrap_add(rp_q, (item_i.action == ACT_PEEK) ? PW'(item_i.count) : '0,
                         size_q);
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        size_d = SW'(1);
      end else if (32'(cfg_wdata_i) > MAX_SLOTS) begin
        size_d = SW'(MAX_SLOTS);
      end else begin
        size_d = SW'(cfg_wdata_i);
      end
      wp_d    = '0;
      rp_d    = '0;
      tlen_d  = '0;
      tbusy_d = 1'b0;
    end else if (mod_done) begin
      if (tail_q) begin
        rp_d = mod_rem;
      end else begin
        wp_d = mod_rem;
      end
      valid_d = 1'b1;
    end else if (accept) begin
      valid_d = 1'b1;
      case (item_i.action)
        ACT_WRITE: begin
          if (32'(held_q) + 32'd1 != 32'(size_q)) begin
            ram_we = 1'b1;
            wp_d   = wrap_add(wp_q, PW'(1), size_q);
            ok_d   = 1'b1;
          end
        end
        ACT_READ: begin
          if (held_q != '0) begin
            rp_d    = wrap_add(rp_q, PW'(1), size_q);
            ok_d    = 1'b1;
            rdsel_d = 1'b1;
          end
        end
        ACT_PEEK: begin
          if (32'(item_i.count) < 32'(held_q)) begin
            ok_d    = 1'b1;
            rdsel_d = 1'b1;
          end
        end
        ACT_SKIP: begin
          rp_d = wrap_add(rp_q, skip_n, size_q);
        end
        ACT_FLUSH: begin
          rp_d = wp_q;
        end
        ACT_FETCH: begin
          if (!tbusy_q && held_q != '0) begin
            ok_d     = 1'b1;
            cstart_d = rp_q;
            clen_d   = (wp_q >= rp_q) ? wp_q - rp_q : PW'(size_q - SW'(rp_q));
            tlen_d   = clen_d;
            tbusy_d  = 1'b1;
          end
        end
        ACT_COMPLETE: begin
          if (tlen_q != '0) begin
            rp_c = wrap_add(rp_q, (tlen_q < held_q) ? tlen_q : held_q, size_q);
          end
          held_c  = held_f(wp_q, rp_c, size_q);
          rp_d    = rp_c;
          tlen_d  = '0;
          tbusy_d = 1'b0;
          if (item_i.want_next && held_c != '0) begin
            ok_d     = 1'b1;
            cstart_d = rp_c;
            clen_d   = (wp_q >= rp_c) ? wp_q - rp_c : PW'(size_q - SW'(rp_c));
            tlen_d   = clen_d;
            tbusy_d  = 1'b1;
          end
        end
        ACT_SET_HEAD: begin
          mod_start = 1'b1;
          tail_d    = 1'b0;
          valid_d   = 1'b0;
        end
        ACT_SET_TAIL: begin
          mod_start = 1'b1;
          tail_d    = 1'b1;
          valid_d   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SW'(ResetSize);
      wp_q    <= '0;
      rp_q    <= '0;
      tlen_q  <= '0;
      tbusy_q <= 1'b0;
      valid_q <= 1'b0;
      tail_q  <= 1'b0;
    end else begin
      size_q  <= size_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      tlen_q  <= tlen_d;
      tbusy_q <= tbusy_d;
      valid_q <= valid_d;
      tail_q  <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q     <= ok_d;
    rdsel_q  <= rdsel_d;
    cstart_q <= cstart_d;
    clen_q   <= clen_d;
  end

  brf_ram #(
    .WIDTH (DataW),
    .DEPTH (MAX_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (item_i.data_in),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  brf_mod #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (item_i.count),
    .divisor_i  (size_q),
    .busy_o     (mod_busy),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign result_valid_o          = valid_q;
  assign result_o.ok             = ok_q;
  assign result_o.data_out       = rdsel_q ? rdata : '0;
  assign result_o.chunk_start    = brf_cnt_t'(cstart_q);
  assign result_o.chunk_length   = brf_cnt_t'(clen_q);
  assign result_o.readable_count = brf_cnt_t'(held_q);
  assign result_o.writable_count = brf_cnt_t'(size_q - SW'(1) - SW'(held_q));

endmodule
